// File: src/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(name, clk, rst, cond)
`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// File: src/psb_pkg.sv
// types and constants of the palette sprite blitter
`timescale 1ns / 1ps

package psb_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = 8;
  localparam int COLOR_W       = 16;
  localparam int DIM_W         = 12;
  localparam int POS_W         = 16;
  localparam int IDX_W         = 8;
  // placement width: pos +/- axis +/- column, with sign
  localparam int XW            = 19;
  localparam int SX_W          = 9;
  localparam int SY_W          = 8;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  typedef enum logic [2:0] {
    REG_SPRITE_WIDTH  = 3'd0,
    REG_SPRITE_HEIGHT = 3'd1,
    REG_AXIS_X        = 3'd2,
    REG_AXIS_Y        = 3'd3,
    REG_POS_X         = 3'd4,
    REG_POS_Y         = 3'd5,
    REG_FLIP_H        = 3'd6,
    REG_MASK_ENABLE   = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic               mode;
    logic [PAL_AW-1:0]  palette_entry;
    logic [COLOR_W-1:0] palette_color;
    logic [IDX_W-1:0]   pixel_index;
    logic               sprite_start;
  } req_t;

  typedef struct packed {
    logic [SX_W-1:0]    screen_x;
    logic [SY_W-1:0]    screen_y;
    logic [COLOR_W-1:0] color;
  } res_t;

  typedef struct packed {
    logic [DIM_W-1:0]        sprite_width;
    logic [DIM_W-1:0]        sprite_height;
    logic signed [POS_W-1:0] axis_x;
    logic signed [POS_W-1:0] axis_y;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    flip_h;
    logic                    mask_enable;
  } cfg_t;

  // placement of one pixel, handed from the counter logic to stage one
  typedef struct packed {
    logic                 live;
    logic                 keep;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
  } place_t;

endpackage

// File: src/psb_ram.sv
// generic single-clock ram, one write port, one registered read port
`timescale 1ns / 1ps

module psb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/psb_cfg.sv
// configuration register file of the sprite blitter
`timescale 1ns / 1ps

module psb_cfg import psb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr,
  input  logic [2:0]  index,
  input  logic [15:0] data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sprite_width  <= DIM_W'(1);
      cfg.sprite_height <= DIM_W'(1);
      cfg.axis_x        <= '0;
      cfg.axis_y        <= '0;
      cfg.pos_x         <= '0;
      cfg.pos_y         <= '0;
      cfg.flip_h        <= 1'b0;
      cfg.mask_enable   <= 1'b0;
    end else if (wr) begin
      unique case (index)
        REG_SPRITE_WIDTH:  cfg.sprite_width  <= data[DIM_W-1:0];
        REG_SPRITE_HEIGHT: cfg.sprite_height <= data[DIM_W-1:0];
        REG_AXIS_X:        cfg.axis_x        <= $signed(data);
        REG_AXIS_Y:        cfg.axis_y        <= $signed(data);
        REG_POS_X:         cfg.pos_x         <= $signed(data);
        REG_POS_Y:         cfg.pos_y         <= $signed(data);
        REG_FLIP_H:        cfg.flip_h        <= data[0];
        REG_MASK_ENABLE:   cfg.mask_enable   <= data[0];
        default: ;
      endcase
    end
  end

endmodule

// File: src/psb_place.sv
// raster counters, color key and pixel placement
`timescale 1ns / 1ps

module psb_place import psb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             pix_take,
  input  logic [IDX_W-1:0] pixel_index,
  input  logic             sprite_start,
  input  cfg_t             cfg,
  output place_t           place
);

  logic [DIM_W-1:0] column_count;
  logic [DIM_W-1:0] row_count;
  logic [IDX_W-1:0] key_index;

  logic [DIM_W-1:0]     col_eff;
  logic [DIM_W-1:0]     row_eff;
  logic [IDX_W-1:0]     key_eff;
  logic signed [XW-1:0] px, ax, py, ay, cx, ry;
  logic                 row_end;

  always_comb begin
    col_eff = sprite_start ? '0 : column_count;
    row_eff = sprite_start ? '0 : row_count;
    key_eff = sprite_start ? pixel_index : key_index;

    px = XW'(cfg.pos_x);
    ax = XW'(cfg.axis_x);
    py = XW'(cfg.pos_y);
    ay = XW'(cfg.axis_y);
    cx = $signed(XW'(col_eff));
    ry = $signed(XW'(row_eff));

    place.live = row_eff < cfg.sprite_height;
    place.keep = !(cfg.mask_enable && (pixel_index == key_eff));
    // mirrored: pos - (w - axis) + (w - 1 - c) folds to pos + axis - 1 - c
    place.x    = cfg.flip_h ? (px + ax - XW'(1) - cx) : (px - ax + cx);
    place.y    = py - ay + ry;

    row_end = ({1'b0, col_eff} + (DIM_W+1)'(1)) >= {1'b0, cfg.sprite_width};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      key_index    <= '0;
    end else if (pix_take) begin
      key_index <= key_eff;
      if (!place.live) begin
        column_count <= col_eff;
        row_count    <= row_eff;
      end else if (row_end) begin
        column_count <= '0;
        row_count    <= row_eff + DIM_W'(1);
      end else begin
        column_count <= col_eff + DIM_W'(1);
        row_count    <= row_eff;
      end
    end
  end

endmodule

// File: src/palette_sprite_blitter.sv
// top level of the palette sprite blitter
//
//  channel  signals                              direction  carries
//  req      req_valid, req_ready, req            in         palette load or sprite pixel
//  res      res_valid, res_ready, res            out        screen x, y and color
//  cfg      cfg_valid, cfg_ready, cfg_index/data in         register write
//
// one request per cycle sustained while no stall holds it; a pixel's placement
// and palette read are registered in stage one, then its result in the output register.
// reset clears the counters, the key index and both stage valids and sets the
// registers to their defaults; the palette holds garbage until loaded.
// a visible pixel stalled in stage one by a full output register blocks the
// request channel; clipped, keyed and load requests never cause a stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module palette_sprite_blitter import psb_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  output logic        res_valid,
  input  logic        res_ready,
  output res_t        res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t   cfg;
  place_t place;

  logic   req_take;
  logic   pix_take;
  logic   load_take;

  // stage one: placement waiting for the palette read
  logic                 s1_valid;
  logic                 s1_keep;
  logic signed [XW-1:0] s1_x;
  logic signed [XW-1:0] s1_y;
  logic                 s1_show;
  logic                 advance;

  logic [COLOR_W-1:0]   pal_rdata;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  psb_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr    (cfg_valid),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  assign req_take  = req_valid && req_ready;
  assign pix_take  = req_take && (req.mode == MODE_PIXEL);
  assign load_take = req_take && (req.mode == MODE_LOAD);

  psb_place u_place (
    .clk          (clk),
    .rst          (rst),
    .pix_take     (pix_take),
    .pixel_index  (req.pixel_index),
    .sprite_start (req.sprite_start),
    .cfg          (cfg),
    .place        (place)
  );

  // palette: loads write, pixels read, one access per request
  psb_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (load_take),
    .waddr (req.palette_entry),
    .wdata (req.palette_color),
    .re    (pix_take),
    .raddr (req.pixel_index),
    .rdata (pal_rdata)
  );

  // clip against the screen rectangle
  assign s1_show = s1_keep
                && (s1_x >= $signed(XW'(0))) && (s1_x < $signed(XW'(SCREEN_WIDTH)))
                && (s1_y >= $signed(XW'(0))) && (s1_y < $signed(XW'(SCREEN_HEIGHT)));

  // stage one moves on unless it holds a visible pixel and the output is full;
  // the ram read data only holds while no new read is issued
  assign advance   = !s1_valid || !s1_show || !res_valid || res_ready;
  assign req_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= pix_take && place.live;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_keep <= place.keep;
      s1_x    <= place.x;
      s1_y    <= place.y;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_valid && s1_show && advance) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_show && advance) begin
      res.screen_x <= s1_x[SX_W-1:0];
      res.screen_y <= s1_y[SY_W-1:0];
      res.color    <= pal_rdata;
    end
  end

  // a visible pixel facing a full output register holds off new requests
  `ASSERT_IMPLIES(a_stall_blocks_req, clk, rst,
    s1_valid && s1_show && res_valid && !res_ready, !req_ready)

  // a palette load never fills stage one
  `ASSERT_NEXT(a_load_no_stage, clk, rst, load_take, !s1_valid)

  // the palette port never sees a read and a write at once
  `ASSERT_ALWAYS(a_one_access, clk, rst, !(load_take && pix_take))

  // a result appears only from a visible pixel in stage one
  `ASSERT_NEXT(a_res_from_stage, clk, rst,
    !res_valid && !(s1_valid && s1_show), !res_valid)

endmodule

// File: tb/sv/palette_sprite_blitter_test.sv
// self-checking testbench of the palette sprite blitter: directed and random sprites
`timescale 1ns / 1ps
module palette_sprite_blitter_test;
  import psb_pkg::*;

  localparam int SCREEN_W     = 320;
  localparam int SCREEN_H     = 240;
  // margin after the last result before touching registers
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 600;
  // far beyond the slowest legal run
  localparam longint TIMEOUT_NS = 64'd20_000_000;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_style_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  req_t        req;
  logic        res_valid;
  logic        res_ready;
  res_t        res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  palette_sprite_blitter #(
    .SCREEN_WIDTH(SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) uut (.*);

  // shadow copy of the blitter registers and drawing state
  logic [DIM_W-1:0]        spr_width;
  logic [DIM_W-1:0]        spr_height;
  logic signed [POS_W-1:0] axis_x_r;
  logic signed [POS_W-1:0] axis_y_r;
  logic signed [POS_W-1:0] pos_x_r;
  logic signed [POS_W-1:0] pos_y_r;
  logic                    flip_on;
  logic                    mask_on;
  logic [COLOR_W-1:0]      pal_shadow [PALETTE_DEPTH];
  logic [DIM_W-1:0]        col_pos;
  logic [DIM_W-1:0]        row_pos;
  logic [IDX_W-1:0]        key_idx;

  // entries the stimulus has loaded so far, pixels only use these
  bit        pal_loaded [PALETTE_DEPTH];
  res_t      expected_pixels [$];
  int        errors;
  int        items_sent;

  // sender pacing and receiver behavior
  bit        tx_bursty;
  int        burst_left;
  rx_style_t rx_style;
  logic [7:0] rx_pattern;
  bit        hold_armed;
  int        hold_left;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // expected outcome of one accepted request
  function automatic void blit_predict(req_t r);
    int   w, c, rr, ax, ay, px, py, x, y;
    bit   show;
    res_t pix;
    if (r.mode == MODE_LOAD) begin
      // palette write, counters and key stay put, start flag means nothing here
      pal_shadow[r.palette_entry] = r.palette_color;
      return;
    end
    if (r.sprite_start) begin
      // new sprite: restart at the top left and latch the color key
      col_pos = '0;
      row_pos = '0;
      key_idx = r.pixel_index;
    end
    // past the last row nothing moves until the next sprite start
    if (row_pos >= spr_height) return;
    w  = spr_width;
    c  = col_pos;
    rr = row_pos;
    ax = axis_x_r;
    ay = axis_y_r;
    px = pos_x_r;
    py = pos_y_r;
    if (flip_on) begin
      // mirrored: origin moves to width minus axis, column runs backwards
      x = (px - (w - ax)) + (w - 1 - c);
    end else begin
      x = px - ax + c;
    end
    y = py - ay + rr;
    show = x >= 0 && x < SCREEN_W && y >= 0 && y < SCREEN_H;
    if (mask_on && r.pixel_index == key_idx) show = 1'b0;
    // row advance also covers a width of zero or one lowered under the column
    if (c + 1 >= w) begin
      col_pos = '0;
      row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    if (show) begin
      pix.screen_x = x[SX_W-1:0];
      pix.screen_y = y[SY_W-1:0];
      pix.color    = pal_shadow[r.pixel_index];
      expected_pixels.push_back(pix);
    end
  endfunction

  function automatic req_t load_item(logic [IDX_W-1:0] entry, logic [COLOR_W-1:0] color);
    req_t r;
    r.mode          = MODE_LOAD;
    r.palette_entry = entry;
    r.palette_color = color;
    // fields of the other mode carry noise
    r.pixel_index   = IDX_W'($urandom);
    r.sprite_start  = 1'($urandom);
    return r;
  endfunction

  function automatic req_t pixel_item(logic [IDX_W-1:0] idx, bit start);
    req_t r;
    r.mode          = MODE_PIXEL;
    r.palette_entry = PAL_AW'($urandom);
    r.palette_color = COLOR_W'($urandom);
    r.pixel_index   = idx;
    r.sprite_start  = start;
    return r;
  endfunction

  // random index among the loaded palette entries
  function automatic logic [IDX_W-1:0] pick_index();
    int i;
    do i = $urandom_range(0, PALETTE_DEPTH - 1); while (!pal_loaded[i]);
    return i[IDX_W-1:0];
  endfunction

  // mostly a plain range, now and then a 16-bit extreme
  function automatic int rand_span(int lo, int hi);
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return 32767;
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  // random gaps between bursts of requests
  task automatic pace_sender();
    int gap;
    if (!tx_bursty) return;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  // offer one request and hold it until the block takes it
  task automatic send_request(req_t item);
    pace_sender();
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    if (item.mode == MODE_LOAD) pal_loaded[item.palette_entry] = 1'b1;
    blit_predict(item);
    items_sent++;
  endtask

  // stop offering, let every expected pixel come out, then wait out the drain margin
  task automatic wait_idle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(reg_index_t idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SPRITE_WIDTH:  spr_width  = data[DIM_W-1:0];
      REG_SPRITE_HEIGHT: spr_height = data[DIM_W-1:0];
      REG_AXIS_X:        axis_x_r   = data;
      REG_AXIS_Y:        axis_y_r   = data;
      REG_POS_X:         pos_x_r    = data;
      REG_POS_Y:         pos_y_r    = data;
      REG_FLIP_H:        flip_on    = data[0];
      REG_MASK_ENABLE:   mask_on    = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // full register set; unused upper bits of the narrow registers get noise
  task automatic set_sprite(int w, int h, int ax, int ay, int px, int py, bit flip, bit mask);
    logic [15:0] d;
    wait_idle();
    d = 16'($urandom);
    d[DIM_W-1:0] = w[DIM_W-1:0];
    write_register(REG_SPRITE_WIDTH, d);
    d = 16'($urandom);
    d[DIM_W-1:0] = h[DIM_W-1:0];
    write_register(REG_SPRITE_HEIGHT, d);
    write_register(REG_AXIS_X, ax[15:0]);
    write_register(REG_AXIS_Y, ay[15:0]);
    write_register(REG_POS_X, px[15:0]);
    write_register(REG_POS_Y, py[15:0]);
    d = 16'($urandom);
    d[0] = flip;
    write_register(REG_FLIP_H, d);
    d = 16'($urandom);
    d[0] = mask;
    write_register(REG_MASK_ENABLE, d);
  endtask

  // palette extremes, then a single pixel sprite with the reset registers
  task automatic test_palette_and_reset_sprite();
    send_request(load_item(8'h00, 16'h0000));
    send_request(load_item(8'hFF, 16'hFFFF));
    send_request(load_item(8'h55, 16'hA5A5));
    send_request(load_item(8'hAA, 16'h5A5A));
    send_request(pixel_item(8'hFF, 1'b1));
    // second pixel lies past the only row
    send_request(pixel_item(8'h00, 1'b0));
  endtask

  // bottom right corner clip, then mirrored sprite with color key
  task automatic test_clip_and_flip();
    set_sprite(3, 2, 0, 0, 318, 239, 1'b0, 1'b0);
    send_request(pixel_item(8'hAA, 1'b1));
    send_request(pixel_item(8'h55, 1'b0));
    send_request(pixel_item(8'h00, 1'b0));
    send_request(pixel_item(8'hFF, 1'b0));
    send_request(pixel_item(8'h55, 1'b0));
    set_sprite(3, 2, 1, -3, 5, 0, 1'b1, 1'b1);
    send_request(pixel_item(8'h55, 1'b1));
    send_request(pixel_item(8'hAA, 1'b0));
    send_request(pixel_item(8'hFF, 1'b0));
    send_request(pixel_item(8'h55, 1'b0));
    send_request(pixel_item(8'h00, 1'b0));
  endtask

  // width lowered under the column, width of zero, height of zero
  task automatic test_counter_edges();
    set_sprite(6, 3, 0, 0, 10, 10, 1'b0, 1'b0);
    send_request(pixel_item(8'hAA, 1'b1));
    repeat (3) send_request(pixel_item(8'h55, 1'b0));
    // column is now 4, past the new width
    set_sprite(2, 3, 0, 0, 10, 10, 1'b0, 1'b0);
    repeat (3) send_request(pixel_item(8'hFF, 1'b0));
    set_sprite(0, 3, 0, 0, 7, 200, 1'b0, 1'b0);
    send_request(pixel_item(8'hAA, 1'b1));
    repeat (3) send_request(pixel_item(8'h00, 1'b0));
    set_sprite(3, 0, 0, 0, 7, 7, 1'b0, 1'b0);
    send_request(pixel_item(8'hFF, 1'b1));
  endtask

  // receiver holds off while a fully visible sprite streams in
  task automatic test_backpressure();
    int n;
    set_sprite(8, 8, 0, 0, 100, 100, 1'b0, 1'b0);
    tx_bursty = 1'b0;
    rx_style  = RX_ALWAYS;
    hold_armed = 1'b1;
    for (n = 0; n < 64; n++) send_request(pixel_item(pick_index(), n == 0));
  endtask

  // one sprite: start, raster content, loads and stray starts mixed in
  task automatic random_sprite();
    int total, n;
    logic [IDX_W-1:0] first;
    total = spr_width * spr_height;
    // large sprites are cut short, small ones may run past their end
    if (total > 48) total = $urandom_range(8, 48);
    else total = total + $urandom_range(0, 2);
    first = pick_index();
    send_request(pixel_item(first, 1'b1));
    for (n = 1; n < total; n++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_request(load_item(IDX_W'($urandom), COLOR_W'($urandom)));
      end
      if ($urandom_range(0, 3) == 0) begin
        send_request(pixel_item(first, $urandom_range(0, 39) == 0));
      end else begin
        send_request(pixel_item(pick_index(), $urandom_range(0, 39) == 0));
      end
    end
  endtask

  task automatic test_random_sprites();
    int i, first_item, w, h;
    tx_bursty = 1'b1;
    rx_style  = RX_RANDOM;
    first_item = items_sent;
    for (i = 0; i < PALETTE_DEPTH; i++) begin
      send_request(load_item(IDX_W'(i), COLOR_W'($urandom)));
    end
    while (items_sent - first_item < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: w = 4095;
        1: w = $urandom_range(17, 400);
        default: w = $urandom_range(1, 16);
      endcase
      case ($urandom_range(0, 9))
        0: h = 4095;
        1: h = $urandom_range(13, 300);
        default: h = $urandom_range(1, 12);
      endcase
      set_sprite(w, h, rand_span(-8, 8), rand_span(-8, 8), rand_span(-20, 340),
                 rand_span(-20, 260), 1'($urandom), 1'($urandom));
      tx_bursty  = $urandom_range(0, 3) != 0;
      rx_style   = rx_style_t'($urandom_range(0, 3));
      rx_pattern = 8'($urandom) | 8'h01;
      repeat ($urandom_range(1, 3)) random_sprite();
    end
  endtask

  // receiver: a long hold-off when armed, otherwise the current style
  always @(negedge clk) begin
    if (hold_armed) begin
      hold_left  = HOLD_CYCLES;
      hold_armed = 1'b0;
    end
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else begin
      case (rx_style)
        RX_ALWAYS: res_ready <= 1'b1;
        RX_RANDOM: res_ready <= $urandom_range(0, 3) != 0;
        RX_PATTERN: begin
          res_ready  <= rx_pattern[0];
          rx_pattern  = {rx_pattern[0], rx_pattern[7:1]};
        end
        default: res_ready <= $urandom_range(0, 3) == 0;
      endcase
    end
  end

  // every pixel the block hands over is matched with the oldest expectation
  always @(posedge clk) begin : check_pixels
    res_t want;
    if (!rst && res_valid && res_ready) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d color=%h",
                 $time, res.screen_x, res.screen_y, res.color);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (res.screen_x !== want.screen_x) begin
          $display("%0t: screen_x expected %0d actual %0d", $time, want.screen_x, res.screen_x);
          errors++;
        end
        if (res.screen_y !== want.screen_y) begin
          $display("%0t: screen_y expected %0d actual %0d", $time, want.screen_y, res.screen_y);
          errors++;
        end
        if (res.color !== want.color) begin
          $display("%0t: color expected %h actual %h", $time, want.color, res.color);
          errors++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[palette_sprite_blitter] ERROR");
    $finish;
  end

  initial begin
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    res_ready  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    // state after reset
    spr_width  = 1;
    spr_height = 1;
    axis_x_r   = '0;
    axis_y_r   = '0;
    pos_x_r    = '0;
    pos_y_r    = '0;
    flip_on    = 1'b0;
    mask_on    = 1'b0;
    col_pos    = '0;
    row_pos    = '0;
    key_idx    = '0;
    errors     = 0;
    items_sent = 0;
    tx_bursty  = 1'b0;
    burst_left = 0;
    rx_style   = RX_RANDOM;
    rx_pattern = 8'hB5;
    hold_armed = 1'b0;
    hold_left  = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_palette_and_reset_sprite();
    test_clip_and_flip();
    test_counter_edges();
    test_backpressure();
    test_random_sprites();
    wait_idle();

    if (errors == 0) begin
      $display("[palette_sprite_blitter] OK");
    end else begin
      $display("[palette_sprite_blitter] ERROR");
    end
    $finish;
  end

endmodule
